// ===== rtl/pcrg_pkg.sv =====
// Shared types, constants and helpers for the pinhole camera ray generator.
// No dependencies; every other file imports this package.
package pcrg_pkg;

    localparam int COMP_BITS     = 21;
    localparam int CFG_BITS      = 3 * COMP_BITS;
    localparam int PIX_PORT_BITS = 12;
    localparam int MAG_BITS      = 24;
    localparam int OUT_FRAC      = 15;
    localparam int OUT_BITS      = 16;
    localparam int SQ_BITS       = 2 * MAG_BITS;
    localparam int SUM_BITS      = SQ_BITS + 2;
    localparam int ROOT_BITS     = SUM_BITS / 2;
    localparam int QUO_BITS      = 16;
    localparam int NUM_BITS      = MAG_BITS + OUT_FRAC + 1;

    localparam logic [OUT_BITS-1:0] POS_LIMIT = 16'd32767;
    localparam logic [OUT_BITS-1:0] NEG_LIMIT = 16'd32768;

    typedef logic [1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_CORNER = 2'd0;
    localparam cfg_idx_t CFG_STEP_X = 2'd1;
    localparam cfg_idx_t CFG_STEP_Y = 2'd2;

    typedef logic [MAG_BITS-1:0] mag_t;

    typedef struct packed {
        mag_t [2:0] mag;
        logic [2:0] neg;
        logic       deg;
    } pcrg_item_t;

    function automatic logic signed [COMP_BITS-1:0] get_comp(
        input logic [CFG_BITS-1:0] packed_reg,
        input int                  k
    );
        return signed'(packed_reg[k*COMP_BITS +: COMP_BITS]);
    endfunction

endpackage

// ===== rtl/pcrg_front.sv =====
// Front part: forms the unnormalized direction per pixel and scales it to 24 bits.
// Depends on pcrg_pkg.
module pcrg_front
    import pcrg_pkg::*;
#(
    parameter int PIXEL_BITS = 12
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     adv,
    input  logic                     in_valid,
    input  logic [PIX_PORT_BITS-1:0] pixel_x,
    input  logic [PIX_PORT_BITS-1:0] pixel_y,
    input  logic [CFG_BITS-1:0]      corner,
    input  logic [CFG_BITS-1:0]      step_x,
    input  logic [CFG_BITS-1:0]      step_y,
    output logic                     out_valid,
    output pcrg_item_t               out_item
);

    localparam int PU        = (PIXEL_BITS < PIX_PORT_BITS) ? PIXEL_BITS : PIX_PORT_BITS;
    localparam int PROD_BITS = COMP_BITS + PU + 1;
    localparam int DW        = COMP_BITS + PU + 2;
    localparam int POS_BITS  = $clog2(DW);
    localparam int SH_BITS   = DW + MAG_BITS - 1;

    logic signed [PU:0]           px_s;
    logic signed [PU:0]           py_s;
    logic signed [PROD_BITS-1:0]  prod_x [3];
    logic signed [PROD_BITS-1:0]  prod_y [3];
    logic signed [DW-1:0]         dsum   [3];
    logic [DW-1:0]                orv;
    logic [POS_BITS-1:0]          pos;
    logic [SH_BITS-1:0]           sh     [3];

    logic                         v1_reg;
    logic signed [PROD_BITS-1:0]  prx_reg [3];
    logic signed [PROD_BITS-1:0]  pry_reg [3];
    logic                         v2_reg;
    logic [DW-1:0]                a2_reg  [3];
    logic [2:0]                   n2_reg;
    logic                         v3_reg;
    logic [DW-1:0]                a3_reg  [3];
    logic [2:0]                   n3_reg;
    logic                         deg3_reg;
    logic [POS_BITS-1:0]          pos3_reg;
    logic                         v4_reg;
    pcrg_item_t                   item4_reg;

    assign px_s = signed'({1'b0, pixel_x[PU-1:0]});
    assign py_s = signed'({1'b0, pixel_y[PU-1:0]});

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            prod_x[k] = px_s * get_comp(step_x, k);
            prod_y[k] = py_s * get_comp(step_y, k);
            dsum[k]   = DW'(get_comp(corner, k)) + DW'(prx_reg[k]) + DW'(pry_reg[k]);
        end
    end

    always_comb
    begin
        orv = a2_reg[0] | a2_reg[1] | a2_reg[2];
        pos = '0;
        for (int i = 0; i < DW; i++)
        begin
            if (orv[i])
            begin
                pos = POS_BITS'(i);
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sh[k] = {a3_reg[k], {(MAG_BITS-1){1'b0}}} >> pos3_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                prx_reg[k] <= prod_x[k];
                pry_reg[k] <= prod_y[k];
                n2_reg[k]  <= dsum[k][DW-1];
                a2_reg[k]  <= dsum[k][DW-1] ? DW'(-dsum[k]) : DW'(dsum[k]);
                a3_reg[k]  <= a2_reg[k];
                item4_reg.mag[k] <= sh[k][MAG_BITS-1:0];
            end
            n3_reg         <= n2_reg;
            deg3_reg       <= (orv == '0);
            pos3_reg       <= pos;
            item4_reg.neg  <= n3_reg;
            item4_reg.deg  <= deg3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign out_item  = item4_reg;

endmodule

// ===== rtl/pcrg_queue.sv =====
// Short transaction queue between the front and back parts.
// Depends on pcrg_pkg for the item type.
module pcrg_queue
    import pcrg_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  pcrg_item_t push_item,
    input  logic       pop,
    output pcrg_item_t pop_item,
    output logic       full,
    output logic       empty
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    pcrg_item_t            mem_reg [DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg;
    logic [PTR_BITS-1:0]   wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg;
    logic [PTR_BITS-1:0]   rd_ptr_next;
    logic [CNT_BITS-1:0]   count_reg;
    logic [CNT_BITS-1:0]   count_next;

    assign full     = (count_reg == CNT_BITS'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
        else $error("queue pop while empty");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(DEPTH))
        else $error("queue count out of range");
    a_count_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not advance on push");

endmodule

// ===== rtl/pcrg_back.sv =====
// Back part: squares, pipelined square root, pipelined division, saturation, output register.
// Depends on pcrg_pkg.
module pcrg_back
    import pcrg_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  pcrg_item_t                 in_item,
    output logic                       pop,
    input  logic                       out_stall,
    output logic                       out_valid,
    output logic signed [OUT_BITS-1:0] dir_x,
    output logic signed [OUT_BITS-1:0] dir_y,
    output logic signed [OUT_BITS-1:0] dir_z,
    output logic                       degenerate
);

    localparam int REM_BITS  = ROOT_BITS + 2;
    localparam int DREM_BITS = ROOT_BITS + 1;

    logic adv;

    // squares and sum
    logic                  v1_reg;
    logic [SQ_BITS-1:0]    sq1_reg  [3];
    pcrg_item_t            it1_reg;
    logic                  v2_reg;
    logic [SUM_BITS-1:0]   sum2_reg;
    pcrg_item_t            it2_reg;

    // square root pipeline
    logic [SUM_BITS-1:0]   rad_in   [ROOT_BITS];
    logic [REM_BITS-1:0]   rem_in   [ROOT_BITS];
    logic [ROOT_BITS-1:0]  root_in  [ROOT_BITS];
    pcrg_item_t            sit_in   [ROOT_BITS];
    logic                  sv_in    [ROOT_BITS];
    logic [SUM_BITS-1:0]   rad_reg  [ROOT_BITS];
    logic [REM_BITS-1:0]   rem_reg  [ROOT_BITS];
    logic [ROOT_BITS-1:0]  root_reg [ROOT_BITS];
    pcrg_item_t            sit_reg  [ROOT_BITS];
    logic                  sv_reg   [ROOT_BITS];

    // numerator setup
    logic                  pv_reg;
    logic [NUM_BITS-1:0]   num_reg  [3];
    logic [ROOT_BITS-1:0]  pr_reg;
    logic [2:0]            pneg_reg;
    logic                  pdeg_reg;

    // division pipeline
    logic [DREM_BITS-1:0]  drem_in  [QUO_BITS][3];
    logic [QUO_BITS-1:0]   lo_in    [QUO_BITS][3];
    logic [QUO_BITS-1:0]   q_in     [QUO_BITS][3];
    logic [ROOT_BITS-1:0]  dr_in    [QUO_BITS];
    logic [2:0]            dneg_in  [QUO_BITS];
    logic                  ddeg_in  [QUO_BITS];
    logic                  dv_in    [QUO_BITS];
    logic [DREM_BITS-1:0]  drem_reg [QUO_BITS][3];
    logic [QUO_BITS-1:0]   lo_reg   [QUO_BITS][3];
    logic [QUO_BITS-1:0]   q_reg    [QUO_BITS][3];
    logic [ROOT_BITS-1:0]  dr_reg   [QUO_BITS];
    logic [2:0]            dneg_reg [QUO_BITS];
    logic                  ddeg_reg [QUO_BITS];
    logic                  dv_reg   [QUO_BITS];

    // output
    logic [OUT_BITS-1:0]   sat      [3];
    logic                  out_valid_reg;
    logic [OUT_BITS-1:0]   dir_reg  [3];
    logic                  deg_reg;

    assign adv = !out_valid_reg || !out_stall;
    assign pop = adv && in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            pv_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            pv_reg <= sv_reg[ROOT_BITS-1];
            out_valid_reg <= dv_reg[QUO_BITS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                sq1_reg[k] <= in_item.mag[k] * in_item.mag[k];
            end
            it1_reg  <= in_item;
            sum2_reg <= SUM_BITS'(sq1_reg[0]) + SUM_BITS'(sq1_reg[1]) + SUM_BITS'(sq1_reg[2]);
            it2_reg  <= it1_reg;
        end
    end

    for (genvar j = 0; j < ROOT_BITS; j++)
    begin : g_sqrt
        logic [REM_BITS-1:0] cur;
        logic [REM_BITS-1:0] trial;

        if (j == 0)
        begin : g_first
            assign rad_in[j]  = sum2_reg;
            assign rem_in[j]  = '0;
            assign root_in[j] = '0;
            assign sit_in[j]  = it2_reg;
            assign sv_in[j]   = v2_reg;
        end
        else
        begin : g_next
            assign rad_in[j]  = rad_reg[j-1];
            assign rem_in[j]  = rem_reg[j-1];
            assign root_in[j] = root_reg[j-1];
            assign sit_in[j]  = sit_reg[j-1];
            assign sv_in[j]   = sv_reg[j-1];
        end

        assign cur   = {rem_in[j][REM_BITS-3:0], rad_in[j][SUM_BITS-1 -: 2]};
        assign trial = {root_in[j], 2'b01};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sv_reg[j] <= 1'b0;
            end
            else if (adv)
            begin
                sv_reg[j] <= sv_in[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rad_reg[j] <= {rad_in[j][SUM_BITS-3:0], 2'b00};
                sit_reg[j] <= sit_in[j];
                if (cur >= trial)
                begin
                    rem_reg[j]  <= cur - trial;
                    root_reg[j] <= {root_in[j][ROOT_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[j]  <= cur;
                    root_reg[j] <= {root_in[j][ROOT_BITS-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                num_reg[k] <= {1'b0, sit_reg[ROOT_BITS-1].mag[k], {OUT_FRAC{1'b0}}}
                            + NUM_BITS'(root_reg[ROOT_BITS-1] >> 1);
            end
            pr_reg   <= root_reg[ROOT_BITS-1];
            pneg_reg <= sit_reg[ROOT_BITS-1].neg;
            pdeg_reg <= sit_reg[ROOT_BITS-1].deg;
        end
    end

    for (genvar j = 0; j < QUO_BITS; j++)
    begin : g_div
        if (j == 0)
        begin : g_first
            for (genvar k = 0; k < 3; k++)
            begin : g_lane
                assign drem_in[j][k] = DREM_BITS'(num_reg[k][NUM_BITS-1:QUO_BITS]);
                assign lo_in[j][k]   = num_reg[k][QUO_BITS-1:0];
                assign q_in[j][k]    = '0;
            end
            assign dr_in[j]   = pr_reg;
            assign dneg_in[j] = pneg_reg;
            assign ddeg_in[j] = pdeg_reg;
            assign dv_in[j]   = pv_reg;
        end
        else
        begin : g_next
            for (genvar k = 0; k < 3; k++)
            begin : g_lane
                assign drem_in[j][k] = drem_reg[j-1][k];
                assign lo_in[j][k]   = lo_reg[j-1][k];
                assign q_in[j][k]    = q_reg[j-1][k];
            end
            assign dr_in[j]   = dr_reg[j-1];
            assign dneg_in[j] = dneg_reg[j-1];
            assign ddeg_in[j] = ddeg_reg[j-1];
            assign dv_in[j]   = dv_reg[j-1];
        end

        for (genvar k = 0; k < 3; k++)
        begin : g_step
            logic [DREM_BITS-1:0] cur;

            assign cur = {drem_in[j][k][DREM_BITS-2:0], lo_in[j][k][QUO_BITS-1]};

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    lo_reg[j][k] <= {lo_in[j][k][QUO_BITS-2:0], 1'b0};
                    if (cur >= {1'b0, dr_in[j]})
                    begin
                        drem_reg[j][k] <= cur - {1'b0, dr_in[j]};
                        q_reg[j][k]    <= {q_in[j][k][QUO_BITS-2:0], 1'b1};
                    end
                    else
                    begin
                        drem_reg[j][k] <= cur;
                        q_reg[j][k]    <= {q_in[j][k][QUO_BITS-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_reg[j] <= 1'b0;
            end
            else if (adv)
            begin
                dv_reg[j] <= dv_in[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dr_reg[j]   <= dr_in[j];
                dneg_reg[j] <= dneg_in[j];
                ddeg_reg[j] <= ddeg_in[j];
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (ddeg_reg[QUO_BITS-1])
            begin
                sat[k] = '0;
            end
            else if (dneg_reg[QUO_BITS-1][k])
            begin
                sat[k] = (q_reg[QUO_BITS-1][k] > NEG_LIMIT) ? NEG_LIMIT : q_reg[QUO_BITS-1][k];
                sat[k] = OUT_BITS'(-sat[k]);
            end
            else
            begin
                sat[k] = (q_reg[QUO_BITS-1][k] > POS_LIMIT) ? POS_LIMIT : q_reg[QUO_BITS-1][k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                dir_reg[k] <= sat[k];
            end
            deg_reg <= ddeg_reg[QUO_BITS-1];
        end
    end

    assign out_valid  = out_valid_reg;
    assign dir_x      = signed'(dir_reg[0]);
    assign dir_y      = signed'(dir_reg[1]);
    assign dir_z      = signed'(dir_reg[2]);
    assign degenerate = deg_reg;

    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && degenerate) |-> (dir_x == '0 && dir_y == '0 && dir_z == '0))
        else $error("degenerate result with nonzero direction");
    a_pop_moves: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> v1_reg)
        else $error("popped transaction not captured");
    a_out_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && dv_reg[QUO_BITS-1]) |=> out_valid_reg)
        else $error("finished transaction not presented");

endmodule

// ===== rtl/pinhole_camera_ray_generator.sv =====
// Pinhole camera primary ray generator: takes one pixel per cycle and returns the
// unit ray direction in signed Q1.15. Accepts one transaction every clock
// cycle when the output is not stalled; from accept to result a transaction passes
// 4 front stages, 1 queue, 2 square/sum stages, 25 square-root stages, 1 numerator
// stage, 16 divider stages and 1 output register, since the square root and divider
// compute one bit per stage. The front stalls only when its 4-entry queue is full.
// Configuration registers must be written while no transaction is in flight.
module pinhole_camera_ray_generator
    import pcrg_pkg::*;
#(
    parameter int PIXEL_BITS  = 12,
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  cfg_idx_t                   cfg_index,
    input  logic [CFG_BITS-1:0]        cfg_wdata,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [PIX_PORT_BITS-1:0]   pixel_x,
    input  logic [PIX_PORT_BITS-1:0]   pixel_y,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [OUT_BITS-1:0] dir_x,
    output logic signed [OUT_BITS-1:0] dir_y,
    output logic signed [OUT_BITS-1:0] dir_z,
    output logic                       degenerate
);

    logic [CFG_BITS-1:0] corner_reg;
    logic [CFG_BITS-1:0] step_x_reg;
    logic [CFG_BITS-1:0] step_y_reg;

    logic        q_full;
    logic        q_empty;
    logic        f_valid;
    pcrg_item_t  f_item;
    logic        q_push;
    logic        q_pop;
    pcrg_item_t  q_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corner_reg <= '0;
            step_x_reg <= '0;
            step_y_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_CORNER: corner_reg <= cfg_wdata;
                CFG_STEP_X: step_x_reg <= cfg_wdata;
                CFG_STEP_Y: step_y_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign in_stall = q_full;
    assign q_push   = f_valid && !q_full;

    pcrg_front #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (!q_full),
        .in_valid  (in_valid),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .corner    (corner_reg),
        .step_x    (step_x_reg),
        .step_y    (step_y_reg),
        .out_valid (f_valid),
        .out_item  (f_item)
    );

    pcrg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (f_item),
        .pop       (q_pop),
        .pop_item  (q_item),
        .full      (q_full),
        .empty     (q_empty)
    );

    pcrg_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (!q_empty),
        .in_item    (q_item),
        .pop        (q_pop),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .dir_x      (dir_x),
        .dir_y      (dir_y),
        .dir_z      (dir_z),
        .degenerate (degenerate)
    );

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for pinhole_camera_ray_generator: drives pixels and
// register writes, predicts each unit ray direction and checks every result.
// Depends on pcrg_pkg and the block's RTL.
module tb_top;
    import pcrg_pkg::*;

    localparam cfg_idx_t CFG_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT  = 600000;

    typedef struct {
        logic signed [OUT_BITS-1:0] x;
        logic signed [OUT_BITS-1:0] y;
        logic signed [OUT_BITS-1:0] z;
        logic                       deg;
    } ray_dir_t;

    class ray_scoreboard;
        logic [CFG_BITS-1:0] corner;
        logic [CFG_BITS-1:0] sx;
        logic [CFG_BITS-1:0] sy;
        ray_dir_t            pending_dirs[$];
        int                  errors;

        function new();
            corner = '0;
            sx     = '0;
            sy     = '0;
            errors = 0;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [CFG_BITS-1:0] val);
            case (idx)
                CFG_CORNER: corner = val;
                CFG_STEP_X: sx     = val;
                CFG_STEP_Y: sy     = val;
                default: ;
            endcase
        endfunction

        function longint comp(logic [CFG_BITS-1:0] r, int k);
            logic signed [COMP_BITS-1:0] c;
            c = r[k*COMP_BITS +: COMP_BITS];
            return longint'(c);
        endfunction

        function longint unsigned int_sqrt(longint unsigned n);
            longint unsigned res;
            longint unsigned b;
            res = 0;
            b   = 64'd1 << 62;
            while (b > n)
                b >>= 2;
            while (b != 0)
            begin
                if (n >= res + b)
                begin
                    n   -= res + b;
                    res  = (res >> 1) + b;
                end
                else
                    res >>= 1;
                b >>= 2;
            end
            return res;
        endfunction

        function void note_pixel(logic [PIX_PORT_BITS-1:0] px, logic [PIX_PORT_BITS-1:0] py);
            longint          d;
            longint unsigned mag[3];
            bit              neg[3];
            longint unsigned m;
            longint unsigned s;
            longint unsigned r;
            longint unsigned q;
            logic [OUT_BITS-1:0] o[3];
            ray_dir_t        e;
            m = 0;
            for (int k = 0; k < 3; k++)
            begin
                d = comp(corner, k) + longint'(px) * comp(sx, k) + longint'(py) * comp(sy, k);
                neg[k] = d < 0;
                mag[k] = neg[k] ? longint'(-d) : longint'(d);
                if (mag[k] > m)
                    m = mag[k];
            end
            if (m == 0)
            begin
                e.x = '0;
                e.y = '0;
                e.z = '0;
                e.deg = 1'b1;
            end
            else
            begin
                while (m >= (64'd1 << MAG_BITS))
                begin
                    m >>= 1;
                    for (int k = 0; k < 3; k++)
                        mag[k] >>= 1;
                end
                while (m < (64'd1 << (MAG_BITS - 1)))
                begin
                    m <<= 1;
                    for (int k = 0; k < 3; k++)
                        mag[k] <<= 1;
                end
                s = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
                r = int_sqrt(s);
                for (int k = 0; k < 3; k++)
                begin
                    q = ((mag[k] << OUT_FRAC) + (r >> 1)) / r;
                    if (neg[k])
                    begin
                        if (q > NEG_LIMIT)
                            q = NEG_LIMIT;
                        o[k] = OUT_BITS'(-q);
                    end
                    else
                    begin
                        if (q > POS_LIMIT)
                            q = POS_LIMIT;
                        o[k] = OUT_BITS'(q);
                    end
                end
                e.x = o[0];
                e.y = o[1];
                e.z = o[2];
                e.deg = 1'b0;
            end
            pending_dirs.push_back(e);
        endfunction

        function void check_dir(ray_dir_t got);
            ray_dir_t e;
            if (pending_dirs.size() == 0)
            begin
                $display("%0t: unexpected result x=%0d y=%0d z=%0d deg=%0b",
                         $time, got.x, got.y, got.z, got.deg);
                errors++;
                return;
            end
            e = pending_dirs.pop_front();
            if (got.x !== e.x)
            begin
                $display("%0t: dir_x expected %0d actual %0d", $time, e.x, got.x);
                errors++;
            end
            if (got.y !== e.y)
            begin
                $display("%0t: dir_y expected %0d actual %0d", $time, e.y, got.y);
                errors++;
            end
            if (got.z !== e.z)
            begin
                $display("%0t: dir_z expected %0d actual %0d", $time, e.z, got.z);
                errors++;
            end
            if (got.deg !== e.deg)
            begin
                $display("%0t: degenerate expected %0b actual %0b", $time, e.deg, got.deg);
                errors++;
            end
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_wr_en;
    cfg_idx_t                   cfg_index;
    logic [CFG_BITS-1:0]        cfg_wdata;
    logic                       in_valid;
    logic                       in_stall;
    logic [PIX_PORT_BITS-1:0]   pixel_x;
    logic [PIX_PORT_BITS-1:0]   pixel_y;
    logic                       out_valid;
    logic                       out_stall;
    logic signed [OUT_BITS-1:0] dir_x;
    logic signed [OUT_BITS-1:0] dir_y;
    logic signed [OUT_BITS-1:0] dir_z;
    logic                       degenerate;

    ray_scoreboard sb;
    int            src_idle;
    int            snk_idle;
    int            cycles;
    int            n_items;

    pinhole_camera_ray_generator dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .dir_x      (dir_x),
        .dir_y      (dir_y),
        .dir_z      (dir_z),
        .degenerate (degenerate)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            out_stall <= ($urandom_range(99) < snk_idle);
        end
    end

    initial
    begin
        ray_dir_t got;
        bit       take;
        forever
        begin
            @(negedge clk);
            take = out_valid && !out_stall && rst_n;
            got.x = dir_x;
            got.y = dir_y;
            got.z = dir_z;
            got.deg = degenerate;
            @(posedge clk);
            if (take)
                sb.check_dir(got);
        end
    end

    function automatic logic [CFG_BITS-1:0] pack3(int a, int b, int c);
        logic [COMP_BITS-1:0] ca;
        logic [COMP_BITS-1:0] cb;
        logic [COMP_BITS-1:0] cc;
        ca = a[COMP_BITS-1:0];
        cb = b[COMP_BITS-1:0];
        cc = c[COMP_BITS-1:0];
        return {cc, cb, ca};
    endfunction

    function automatic logic [CFG_BITS-1:0] rand_reg();
        return CFG_BITS'({$urandom, $urandom});
    endfunction

    task automatic send_pixel(logic [PIX_PORT_BITS-1:0] px, logic [PIX_PORT_BITS-1:0] py);
        bit st;
        while ($urandom_range(99) < src_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel_x  <= px;
        pixel_y  <= py;
        do
        begin
            @(negedge clk);
            st = in_stall;
            @(posedge clk);
        end
        while (st);
        sb.note_pixel(px, py);
        n_items++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_dirs.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_regs(logic [CFG_BITS-1:0] c0, logic [CFG_BITS-1:0] c1,
                              logic [CFG_BITS-1:0] c2);
        logic [CFG_BITS-1:0] vals[3];
        cfg_idx_t            idx[3];
        vals = '{c0, c1, c2};
        idx  = '{CFG_CORNER, CFG_STEP_X, CFG_STEP_Y};
        for (int i = 0; i < 3; i++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= idx[i];
            cfg_wdata <= vals[i];
            sb.write_reg(idx[i], vals[i]);
            @(posedge clk);
        end
        if ($urandom_range(1))
        begin
            cfg_index <= CFG_UNUSED;
            cfg_wdata <= rand_reg();
            @(posedge clk);
        end
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic corner_pixels();
        send_pixel(12'd0, 12'd0);
        send_pixel(12'hFFF, 12'hFFF);
        send_pixel(12'd0, 12'hFFF);
        send_pixel(12'hFFF, 12'd0);
    endtask

    initial
    begin
        int phase;
        int burst;
        sb        = new();
        n_items   = 0;
        src_idle  = 0;
        snk_idle  = 0;
        rst_n     = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_CORNER;
        cfg_wdata = '0;
        in_valid  = 1'b0;
        pixel_x   = '0;
        pixel_y   = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero registers after reset: every ray is degenerate
        send_pixel(12'd5, 12'd9);
        send_pixel(12'hFFF, 12'hFFF);
        drain();

        write_regs(pack3(4096, 0, 0), '0, '0);
        corner_pixels();
        drain();
        write_regs(pack3(0, 0, -4096), '0, '0);
        corner_pixels();
        drain();
        write_regs(pack3(20'hFFFFF, 20'hFFFFF, 20'hFFFFF),
                   pack3(20'hFFFFF, 20'hFFFFF, 20'hFFFFF),
                   pack3(20'hFFFFF, 20'hFFFFF, 20'hFFFFF));
        corner_pixels();
        drain();
        write_regs(pack3(-1048576, -1048576, -1048576),
                   pack3(-1048576, -1048576, -1048576),
                   pack3(-1048576, 1048575, -1048576));
        corner_pixels();
        drain();
        write_regs(pack3(1, -1, 0), pack3(-1, 0, 1), pack3(0, 1, -1));
        corner_pixels();
        drain();

        phase = 0;
        while (n_items < 1650)
        begin
            case (phase % 4)
                0: begin src_idle = 0;  snk_idle = 0;  end
                1: begin src_idle = 57; snk_idle = 0;  end
                2: begin src_idle = 0;  snk_idle = 57; end
                default: begin src_idle = 36; snk_idle = 36; end
            endcase
            case ($urandom_range(5))
                0: write_regs(rand_reg(), '0, '0);
                1: write_regs(pack3($urandom_range(4095) - 2048, $urandom_range(31) - 16,
                                    $urandom_range(8191)),
                              pack3($urandom_range(15) - 8, $urandom_range(15) - 8, 0),
                              pack3(0, $urandom_range(15) - 8, $urandom_range(15) - 8));
                default: write_regs(rand_reg(), rand_reg(), rand_reg());
            endcase
            burst = 60 + $urandom_range(60);
            for (int i = 0; i < burst; i++)
            begin
                if ($urandom_range(9) == 0)
                    send_pixel(PIX_PORT_BITS'($urandom_range(3) * 12'h555),
                               PIX_PORT_BITS'($urandom_range(1) * 12'hFFF));
                else
                    send_pixel(PIX_PORT_BITS'($urandom), PIX_PORT_BITS'($urandom));
            end
            drain();
            phase++;
        end

        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
